>>> rtl/ktlru_pkg.sv
// Shared types and constants for the keyed table with LRU eviction.
package ktlru_pkg;

  localparam int SLOTS_DEF    = 8;
  localparam int KEY_BITS_DEF = 64;

  localparam int KEY_W       = 64;
  localparam int STAMP_W     = 32;
  localparam int SLOT_W      = 3;
  localparam int KIND_W      = 2;
  localparam int OUTCOME_W   = 3;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_TOUCH  = 2'd0,
    KIND_FIND   = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT     = 3'd0,
    OUT_INSERT  = 3'd1,
    OUT_EVICT   = 3'd2,
    OUT_MISS    = 3'd3,
    OUT_REMOVED = 3'd4
  } outcome_t;

  typedef struct packed {
    logic start;
    logic rd_en;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } dp_stat_t;

endpackage

>>> rtl/ktlru_ctrl.sv
// Sequencer that walks the table scan and schedules the commit of each item.
module ktlru_ctrl
  import ktlru_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      // The last entry read is folded into the search results here.
      ST_DRAIN: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

endmodule

>>> rtl/ktlru_dp.sv
// Table storage, scan search, update logic and result register.
module ktlru_dp
  import ktlru_pkg::*;
#(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [KEY_W-1:0]       in_key,
  input  logic [STAMP_W-1:0]     in_now,
  input  ctl_cmd_t               cmd,
  output dp_stat_t               stat,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int EXT_W = IDX_W + SLOT_W;

  // Item registers.
  kind_t                kind_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [STAMP_W-1:0]   now_q;

  // Table storage: valid bits in flops, keys and stamps in memories.
  logic [SLOTS-1:0]     valid;
  logic [KEY_BITS-1:0]  key_mem   [SLOTS];
  logic [STAMP_W-1:0]   stamp_mem [SLOTS];

  // Scan pipeline.
  logic [IDX_W-1:0]     cnt;
  logic                 rd_live;
  logic [IDX_W-1:0]     rd_idx;
  logic                 rd_vld;
  logic [KEY_BITS-1:0]  rd_key;
  logic [STAMP_W-1:0]   rd_stamp;

  // Search results.
  logic                 hit_found;
  logic [IDX_W-1:0]     hit_idx;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic                 min_set;
  logic [IDX_W-1:0]     min_idx;
  logic [STAMP_W-1:0]   min_stamp;

  // Commit decision.
  logic [IDX_W-1:0]     tgt_idx;
  logic                 mem_we;
  logic                 set_v;
  logic                 clr_v;
  logic                 res_found;
  outcome_t             res_outcome;
  logic [EXT_W-1:0]     tgt_ext;

  // Result register.
  logic                 out_found;
  logic [SLOT_W-1:0]    out_slot;
  outcome_t             out_outcome;

  assign stat.scan_last = (cnt == IDX_W'(SLOTS - 1));
  assign stat.out_busy  = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_q <= kind_t'(in_kind);
      key_q  <= in_key[KEY_BITS-1:0];
      now_q  <= in_now;
    end
  end

  // One entry is read per cycle; read data is registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      rd_live <= 1'b0;
    end else begin
      rd_live <= cmd.rd_en;
      if (cmd.start) begin
        cnt <= '0;
      end else if (cmd.rd_en) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx   <= cnt;
    rd_vld   <= valid[cnt];
    rd_key   <= key_mem[cnt];
    rd_stamp <= stamp_mem[cnt];
  end

  // Ties on the stamp keep the lower index because the compare is strict.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      min_set    <= 1'b0;
    end else if (rd_live) begin
      if (rd_vld && (rd_key == key_q) && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= rd_idx;
      end
      if (!rd_vld && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
      if (rd_vld && (!min_set || (rd_stamp < min_stamp))) begin
        min_set   <= 1'b1;
        min_idx   <= rd_idx;
        min_stamp <= rd_stamp;
      end
    end
  end

  always_comb begin
    tgt_idx     = '0;
    mem_we      = 1'b0;
    set_v       = 1'b0;
    clr_v       = 1'b0;
    res_found   = 1'b0;
    res_outcome = OUT_MISS;
    case (kind_q)
      KIND_TOUCH: begin
        res_found = 1'b1;
        mem_we    = 1'b1;
        set_v     = 1'b1;
        if (hit_found) begin
          tgt_idx     = hit_idx;
          res_outcome = OUT_HIT;
        end else if (free_found) begin
          tgt_idx     = free_idx;
          res_outcome = OUT_INSERT;
        end else begin
          tgt_idx     = min_idx;
          res_outcome = OUT_EVICT;
        end
      end
      KIND_FIND: begin
        if (hit_found) begin
          res_found   = 1'b1;
          tgt_idx     = hit_idx;
          res_outcome = OUT_HIT;
        end
      end
      KIND_REMOVE: begin
        if (hit_found) begin
          res_found   = 1'b1;
          clr_v       = 1'b1;
          tgt_idx     = hit_idx;
          res_outcome = OUT_REMOVED;
        end
      end
      default: begin
        tgt_idx = '0;
      end
    endcase
  end

  assign tgt_ext = EXT_W'(tgt_idx);

  always_ff @(posedge clk) begin
    if (cmd.commit && mem_we) begin
      key_mem[tgt_idx]   <= key_q;
      stamp_mem[tgt_idx] <= now_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.commit) begin
      if (set_v) begin
        valid[tgt_idx] <= 1'b1;
      end else if (clr_v) begin
        valid[tgt_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_found   <= res_found;
      out_slot    <= tgt_ext[SLOT_W-1:0];
      out_outcome <= res_outcome;
    end
  end

  assign m_tdata = {1'b0, out_outcome, out_slot, out_found};

  // A commit must never overwrite a result that has not been taken.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(m_tvalid && !m_tready))
    else $error("commit while result register is occupied");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("result not presented after commit");

  // A touch always leaves its slot occupied.
  a_touch_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && (kind_q == KIND_TOUCH)) |=> valid[$past(tgt_idx)])
    else $error("touched slot not valid");

  // Eviction only happens when no slot was free.
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && (res_outcome == OUT_EVICT)) |-> (valid == {SLOTS{1'b1}}))
    else $error("eviction with a free slot");

endmodule

>>> rtl/keyed_table_lru_evict_core.sv
// Top level of the fully associative keyed table with LRU eviction.
//
//  Channel | Direction | Signals                     | Contents
//  s_*     | in        | tvalid tready tdata tuser   | one table operation
//  m_*     | out       | tvalid tready tdata         | one result per operation
//
// Each item runs from accept to the next accept through one read of the key and
// stamp memories per slot, a drain state that folds in the last read, a commit
// state and the idle state in which the next item is accepted. The single read
// port of those memories is why the slots are read one at a time.
// Reset clears all valid bits at once; no clearing pass is needed.
// A stalled result stays in the output register; the next item is accepted and
// scanned meanwhile, and holds in its commit cycle until the register frees.
module keyed_table_lru_evict_core
  import ktlru_pkg::*;
#(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // key[63:0], now_ms[95:64]
  input  logic [KIND_W-1:0]      s_tuser,   // kind[1:0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // found[0], slot[3:1], outcome[6:4], zero[7]
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  ktlru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ktlru_dp #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_kind  (s_tuser),
    .in_key   (s_tdata[KEY_W-1:0]),
    .in_now   (s_tdata[KEY_W+STAMP_W-1:KEY_W]),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
